FILE: src/overlap_window_framer_defines.svh
// ----------------------------------------------------------------------------
// Overlap window framer assertion macros
// Shared property wrappers for the framer's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef OVERLAP_WINDOW_FRAMER_DEFINES_SVH
`define OVERLAP_WINDOW_FRAMER_DEFINES_SVH

// check a consequence in the same cycle as its cause
`define OWF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("overlap_window_framer: same-cycle check failed");

// check a consequence in the cycle after its cause
`define OWF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("overlap_window_framer: next-cycle check failed");

`endif

FILE: src/owf_pkg.sv
// ----------------------------------------------------------------------------
// Overlap window framer package
// Sizes, types and the Blackman coefficient table for the framer.
// ----------------------------------------------------------------------------
package owf_pkg;

   // half-block geometry
   localparam int HALF_LEN = 1024;
   localparam int POS_BITS = $clog2(HALF_LEN);
   localparam logic [POS_BITS-1:0] POS_LAST = POS_BITS'(HALF_LEN - 1);

   // sample and coefficient formats
   localparam int SAMPLE_W  = 16;
   localparam int RESULT_W  = 16;
   localparam int POS_OUT_W = 10;
   localparam int COEF_BITS = 16;
   localparam int COEF_W    = COEF_BITS - 1;
   localparam int DIFF_W    = SAMPLE_W + 1;
   localparam int PROD_W    = DIFF_W + COEF_W + 1;
   localparam int SUM_W     = PROD_W + 1;
   localparam int SHIFT_W   = SUM_W - (COEF_BITS - 1);

   localparam logic [SAMPLE_W-1:0] DC_OFFSET_RESET = SAMPLE_W'(32768);

   // table generation constants (Q2.30)
   localparam longint unsigned WIN_N    = 2 * HALF_LEN - 1;
   localparam longint unsigned ONE_Q30U = 64'd1 << 30;
   localparam longint          ONE_Q30  = 64'sd1 << 30;
   localparam longint unsigned PI_Q30   = 64'd3373259426;

   typedef logic [COEF_W-1:0] coef_type;
   typedef coef_type coef_rom_type [HALF_LEN];
   typedef logic signed [RESULT_W-1:0] result_type;

   // divide a Taylor term by (2i-1)(2i) for series step i
   function automatic longint unsigned taylor_div(input longint unsigned t, input int i);
      case (i)
         1:       return t / 64'd2;
         2:       return t / 64'd12;
         3:       return t / 64'd30;
         4:       return t / 64'd56;
         5:       return t / 64'd90;
         6:       return t / 64'd132;
         7:       return t / 64'd182;
         8:       return t / 64'd240;
         9:       return t / 64'd306;
         10:      return t / 64'd380;
         11:      return t / 64'd462;
         12:      return t / 64'd552;
         default: return t;
      endcase
   endfunction

   // cos(2 pi k / WIN_N) in Q2.30 by quadrant folding and a Taylor series
   function automatic longint cos_q30(input longint unsigned k_in);
      longint unsigned k;
      longint unsigned a;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned mag;
      longint          sum;
      logic            neg;
      k   = k_in % WIN_N;
      neg = 1'b0;
      if (2 * k > WIN_N) begin
         k = WIN_N - k;
      end
      a = 2 * k;
      if (2 * a > WIN_N) begin
         a   = WIN_N - a;
         neg = 1'b1;
      end
      x   = (PI_Q30 * a + WIN_N / 2) / WIN_N;
      x2  = (x * x) >> 30;
      mag = ONE_Q30U;
      sum = ONE_Q30;
      for (int i = 1; i <= 12; i++) begin
         mag = taylor_div((mag * x2) >> 30, i);
         if ((i % 2) == 1) begin
            sum = sum - longint'(mag);
         end else begin
            sum = sum + longint'(mag);
         end
      end
      return neg ? -sum : sum;
   endfunction

   // Blackman window, rounded half up to Q0.(COEF_BITS-1), clamped to range
   function automatic coef_rom_type build_coef_rom();
      coef_rom_type    rom;
      longint          c1;
      longint          c2;
      longint          w;
      longint unsigned q;
      longint unsigned cmax;
      cmax = (64'd1 << (COEF_BITS - 1)) - 64'd1;
      for (int i = 0; i < HALF_LEN; i++) begin
         c1 = cos_q30(longint'(i));
         c2 = cos_q30(longint'(2 * i));
         w  = (42 * ONE_Q30 - 50 * c1 + 8 * c2) / 100;
         if (w < 0) begin
            w = 0;
         end
         q = (longint'(w) + (64'd1 << (30 - COEF_BITS))) >> (31 - COEF_BITS);
         if (q > cmax) begin
            q = cmax;
         end
         rom[i] = q[COEF_W-1:0];
      end
      return rom;
   endfunction

   localparam coef_rom_type COEF_ROM = build_coef_rom();

   // round half up, drop the fraction bits and saturate to the result width
   function automatic result_type round_sat(input logic signed [PROD_W-1:0] prod);
      logic signed [SUM_W-1:0]   biased;
      logic signed [SHIFT_W-1:0] shifted;
      biased  = SUM_W'(prod) + SUM_W'(signed'(64'sd1 << (COEF_BITS - 2)));
      shifted = biased[SUM_W-1:COEF_BITS-1];
      if (shifted > SHIFT_W'(32767)) begin
         return result_type'(16'sh7fff);
      end else if (shifted < -SHIFT_W'(32768)) begin
         return result_type'(16'sh8000);
      end else begin
         return shifted[RESULT_W-1:0];
      end
   endfunction

endpackage

FILE: src/overlap_window_framer.sv
// ----------------------------------------------------------------------------
// Overlap window framer
// Offset removal and Blackman windowing of 50 percent overlapped frames.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ carries one raw ADC sample per word; rsp_ returns one word per
//    sample: the windowed stored sample at frame position m, the windowed
//    new sample at position HALF_LEN+m, m itself and a frame-complete flag.
//  - csr_wr_en/csr_wr_data load the DC offset; write it only while idle.
//  - Acceptance loads the read stage (overlap store and both coefficient
//    table ports); the multiply stage follows, and then the output
//    register through the round/saturate logic, which drives rsp_valid.
//  - Throughput is one word per cycle while the receiver does not stall;
//    the single write/read port of the overlap store is used once per sample.
//  - Reset clears the position counter, filled flag and pipeline valids,
//    and sets the DC offset (32768). The overlap store is not swept: until
//    the first half-block is written, zero stands in for a stored sample.
//  - When the receiver stalls, the whole pipeline holds and req_stall is
//    raised in the same cycle; nothing is dropped.
// ----------------------------------------------------------------------------
`include "overlap_window_framer_defines.svh"

module overlap_window_framer (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       csr_wr_en,
   input  logic [owf_pkg::SAMPLE_W-1:0]               csr_wr_data,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic [owf_pkg::SAMPLE_W-1:0]               req_sample,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic signed [owf_pkg::RESULT_W-1:0]        rsp_early_value,
   output logic signed [owf_pkg::RESULT_W-1:0]        rsp_late_value,
   output logic [owf_pkg::POS_OUT_W-1:0]              rsp_position,
   output logic                                       rsp_frame_done
);

   // control state
   logic [owf_pkg::SAMPLE_W-1:0] dc_offset_ff;
   logic [owf_pkg::POS_BITS-1:0] half_position_ff;
   logic [owf_pkg::POS_BITS-1:0] half_position_in;
   logic                         filled_ff;
   logic                         filled_in;
   logic                         advance;
   logic                         accept;

   // overlap store
   logic [owf_pkg::SAMPLE_W-1:0] store_mem [owf_pkg::HALF_LEN];

   // read stage
   logic                         s1_valid_ff;
   logic                         s1_filled_ff;
   logic [owf_pkg::SAMPLE_W-1:0] s1_stored_ff;
   logic [owf_pkg::SAMPLE_W-1:0] s1_sample_ff;
   logic [owf_pkg::POS_BITS-1:0] s1_pos_ff;
   owf_pkg::coef_type            s1_coef_early_ff;
   owf_pkg::coef_type            s1_coef_late_ff;
   logic signed [owf_pkg::DIFF_W-1:0] diff_early;
   logic signed [owf_pkg::DIFF_W-1:0] diff_late;

   // multiply stage
   logic                                 s2_valid_ff;
   logic [owf_pkg::POS_BITS-1:0]         s2_pos_ff;
   logic signed [owf_pkg::PROD_W-1:0]    s2_prod_early_ff;
   logic signed [owf_pkg::PROD_W-1:0]    s2_prod_late_ff;
   logic signed [owf_pkg::PROD_W-1:0]    s2_prod_early_in;
   logic signed [owf_pkg::PROD_W-1:0]    s2_prod_late_in;

   // output register
   logic                                 rsp_valid_ff;
   owf_pkg::result_type                  rsp_early_ff;
   owf_pkg::result_type                  rsp_late_ff;
   owf_pkg::result_type                  rsp_early_in;
   owf_pkg::result_type                  rsp_late_in;
   logic [owf_pkg::POS_BITS-1:0]         rsp_pos_ff;

   // hold every stage while the output word is stalled
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   // advance the half-block position and mark the store filled after a wrap
   always_comb begin
      half_position_in = half_position_ff;
      filled_in        = filled_ff;
      if (accept) begin
         if (half_position_ff == owf_pkg::POS_LAST) begin
            half_position_in = '0;
            filled_in        = 1'b1;
         end else begin
            half_position_in = half_position_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dc_offset_ff     <= owf_pkg::DC_OFFSET_RESET;
         half_position_ff <= '0;
         filled_ff        <= 1'b0;
         s1_valid_ff      <= 1'b0;
         s2_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            dc_offset_ff <= csr_wr_data;
         end
         half_position_ff <= half_position_in;
         filled_ff        <= filled_in;
         if (advance) begin
            s1_valid_ff  <= req_valid;
            s2_valid_ff  <= s1_valid_ff;
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   // read the old entry, then overwrite it with the new sample
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_stored_ff                <= store_mem[half_position_ff];
         store_mem[half_position_ff] <= req_sample;
      end
   end

   // capture the sample and both window coefficients
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff     <= req_sample;
         s1_pos_ff        <= half_position_ff;
         s1_filled_ff     <= filled_ff;
         s1_coef_early_ff <= owf_pkg::COEF_ROM[half_position_ff];
         s1_coef_late_ff  <= owf_pkg::COEF_ROM[~half_position_ff];
      end
   end

   // remove the DC offset (from zero until the store is filled) and multiply by the window
   always_comb begin
      diff_early = s1_filled_ff
                 ? signed'({1'b0, s1_stored_ff}) - signed'({1'b0, dc_offset_ff})
                 : signed'({1'b0, owf_pkg::SAMPLE_W'(0)}) - signed'({1'b0, dc_offset_ff});
      diff_late  = signed'({1'b0, s1_sample_ff}) - signed'({1'b0, dc_offset_ff});
      s2_prod_early_in = diff_early * signed'({1'b0, s1_coef_early_ff});
      s2_prod_late_in  = diff_late * signed'({1'b0, s1_coef_late_ff});
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         s2_prod_early_ff <= s2_prod_early_in;
         s2_prod_late_ff  <= s2_prod_late_in;
         s2_pos_ff        <= s1_pos_ff;
      end
   end

   // round and saturate into the output register
   always_comb begin
      rsp_early_in = owf_pkg::round_sat(s2_prod_early_ff);
      rsp_late_in  = owf_pkg::round_sat(s2_prod_late_ff);
   end

   always_ff @(posedge clock) begin
      if (advance && s2_valid_ff) begin
         rsp_early_ff <= rsp_early_in;
         rsp_late_ff  <= rsp_late_in;
         rsp_pos_ff   <= s2_pos_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_early_value = rsp_early_ff;
   assign rsp_late_value  = rsp_late_ff;
   assign rsp_position    = owf_pkg::POS_OUT_W'(rsp_pos_ff);
   assign rsp_frame_done  = (rsp_pos_ff == owf_pkg::POS_LAST);

   // checks
   `OWF_ASSERT_NEXT(a_pos_wrap, clock, reset,
      accept && (half_position_ff == owf_pkg::POS_LAST), half_position_ff == '0)
   `OWF_ASSERT_NEXT(a_pipe_advance, clock, reset,
      advance && s1_valid_ff, s2_valid_ff)
   `OWF_ASSERT_NOW(a_filled_only_cleared_by_reset, clock, 1'b0,
      $fell(filled_ff), $past(reset))
   `OWF_ASSERT_NEXT(a_hold_on_stall, clock, reset,
      rsp_valid_ff && rsp_stall,
      rsp_valid_ff && $stable(rsp_early_ff) && $stable(half_position_ff))

endmodule
